[hdl/brfrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfrc_pkg
// shared widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package brfrc_pkg;

  localparam int POS_W = 10;
  localparam int LEN_W = 11;
  localparam int CNT_W = 10;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic clr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
    logic clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/bitmap_range_fill_run_counter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_range_fill_run_counter_unit
// fills a bit range of a word-organized bit vector and counts runs of ones
//
// channel   direction  handshake             payload
// in        in         in_valid / in_ready   first_pos, last_pos, fill_value
// out       out        out_valid / out_ready run_count
// cfg       in         cfg_wr_en             cfg_wr_data (length_in_use)
//
// one beat walks the words up to the effective length through the single
// memory port, doing one read and one write-back per word
// after reset a clearing pass over every word holds in_ready low
// a result waiting on out_ready holds the next beat at the end of its walk
// ----------------------------------------------------------------------------
module bitmap_range_fill_run_counter_unit
  import brfrc_pkg::*;
#(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [POS_W-1:0] first_pos,
  input  wire  [POS_W-1:0] last_pos,
  input  wire              fill_value,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [CNT_W-1:0] run_count,
  input  wire              cfg_wr_en,
  input  wire  [LEN_W-1:0] cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  brfrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  brfrc_datapath #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .first_pos   (first_pos),
    .last_pos    (last_pos),
    .fill_value  (fill_value),
    .run_count   (run_count)
  );

endmodule
`default_nettype wire

[hdl/brfrc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfrc_datapath
// word memory, read-modify-write of one word per step, run start counting
// ----------------------------------------------------------------------------
module brfrc_datapath
  import brfrc_pkg::*;
#(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire                    cfg_wr_en,
  input  wire        [LEN_W-1:0] cfg_wr_data,
  input  wire        [POS_W-1:0] first_pos,
  input  wire        [POS_W-1:0] last_pos,
  input  wire                    fill_value,
  output logic       [CNT_W-1:0] run_count
);

  localparam int NWORDS  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SPAN_W  = $clog2(MAX_BITS + WORD_BITS);
  localparam int PW      = ((SPAN_W > LEN_W) ? SPAN_W : LEN_W) + 1;
  localparam int PC_W    = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rd_data;

  logic [LEN_W-1:0]  length_in_use;
  logic [WIDX_W-1:0] widx;
  logic [PW-1:0]     base;
  logic [PW-1:0]     len_eff;
  logic [PW-1:0]     lo;
  logic [PW-1:0]     hi;
  logic              fv;
  logic              prev;
  logic [LEN_W-1:0]  count;
  logic [WORD_BITS-1:0] starts;

  logic [PW-1:0]        len_cfg;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] cur;
  logic [WORD_BITS-1:0] starts_next;
  logic [LEN_W-1:0]     count_next;

  function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] x);
    logic [PC_W-1:0] s;
    s = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      s = s + PC_W'(x[i]);
    end
    return s;
  endfunction

  assign len_cfg = (PW'(length_in_use) > PW'(MAX_BITS)) ? PW'(MAX_BITS)
                                                         : PW'(length_in_use);

  always_comb begin
    logic [PW-1:0] pos;
    for (int i = 0; i < WORD_BITS; i++) begin
      pos = base + PW'(i);
      new_word[i] = ((pos >= lo) && (pos <= hi) && (pos < len_eff)) ? fv : rd_data[i];
      cur[i]      = new_word[i] & (pos < len_eff);
    end
  end

  generate
    if (WORD_BITS > 1) begin : g_starts
      assign starts_next = cur & ~{cur[WORD_BITS-2:0], prev};
    end else begin : g_starts_one
      assign starts_next = cur & ~prev;
    end
  endgenerate

  assign count_next = count + LEN_W'(popcount(starts));

  assign stat.more     = (base < len_eff);
  assign stat.clr_last = (widx == WIDX_W'(NWORDS - 1));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      widx          <= '0;
      length_in_use <= LEN_RESET;
    end else begin
      if (cfg_wr_en) begin
        length_in_use <= cfg_wr_data;
      end
      if (cmd.load) begin
        widx <= '0;
      end else if (cmd.wr || cmd.clr) begin
        widx <= widx + WIDX_W'(1);
      end
    end
  end

  // word memory
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[widx] <= new_word;
    end else if (cmd.clr) begin
      mem[widx] <= '0;
    end
    if (cmd.rd) begin
      rd_data <= mem[widx];
    end
  end

  // beat payload and accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base    <= '0;
      len_eff <= len_cfg;
      lo      <= PW'(first_pos);
      hi      <= PW'(last_pos);
      fv      <= fill_value;
      prev    <= 1'b0;
      count   <= '0;
    end else begin
      count <= count_next;
      if (cmd.wr) begin
        base <= base + PW'(WORD_BITS);
        prev <= cur[WORD_BITS-1];
      end
    end
    starts <= cmd.wr ? starts_next : '0;
    if (cmd.out_load) begin
      run_count <= (count_next > LEN_W'(COUNT_MAX)) ? COUNT_MAX : count_next[CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hdl/brfrc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfrc_ctrl
// sequencer: clearing pass, per-word read/modify steps, result handoff
// ----------------------------------------------------------------------------
module brfrc_ctrl
  import brfrc_pkg::*;
(
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire           out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:  cmd.clr = 1'b1;
      ST_IDLE:   cmd.load = in_valid;
      ST_READ: begin
        if (stat.more) begin
          cmd.rd = 1'b1;
        end else begin
          cmd.out_load = out_free;
        end
      end
      ST_MODIFY: cmd.wr = 1'b1;
      ST_DONE:   cmd.out_load = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (stat.clr_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state <= ST_READ;
        end
        ST_READ: begin
          if (stat.more) begin
            state <= ST_MODIFY;
          end else if (out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_MODIFY: state <= ST_READ;
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/brfrc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfrc_checker
// port-level checks for the run counter unit
// ----------------------------------------------------------------------------
module brfrc_checker
  import brfrc_pkg::*;
(
  input wire             clk,
  input wire             rst,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire [CNT_W-1:0] run_count
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("outputs active right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_count))
    else $error("stalled result dropped or changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while first is in the walk");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared before the walk could finish");

endmodule

bind bitmap_range_fill_run_counter_unit brfrc_checker u_brfrc_checker (.*);
`default_nettype wire
